// ===== rtl/hrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP response header parser package
// Shared widths, character constants, codes, types and lookup functions.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int CODE_W      = 16;
  localparam int LEN_OUT_W   = 32;
  localparam int STATUS_W    = 3;

  localparam logic [3:0] PREFIX_LEN = 4'd9;
  localparam logic [4:0] KEY_LEN    = 5'd16;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [CODE_W-1:0] CODE_CONTINUE  = 16'd100;
  localparam logic [CODE_W-1:0] CODE_OK        = 16'd200;
  localparam logic [CODE_W-1:0] CODE_NOT_FOUND = 16'd404;
  localparam logic [CODE_W-1:0] CODE_MAX       = 16'hFFFF;

  localparam logic [STATUS_W-1:0] ST_BAD_PROTOCOL = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CONTINUE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNHANDLED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LEN_MISSING  = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PREFIX   = 3'd1,
    PH_CODE     = 3'd2,
    PH_HDR_CONT = 3'd3,
    PH_HDR_OK   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    LS_SEARCH = 2'd0,
    LS_DIGITS = 2'd1,
    LS_DONE   = 2'd2
  } lsearch_t;

  // One received byte after classification by the front end.
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_cr;
    logic       is_lf;
  } byte_info_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CODE_W-1:0]    response_code;
    logic [LEN_OUT_W-1:0] content_length;
    logic                 length_overflow;
  } result_t;

  // "HTTP/1.1 "
  function automatic logic [7:0] proto_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2F;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h31;
      4'd8:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Content-Length: "
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:  c = 8'h43;
      4'd1:  c = 8'h6F;
      4'd2:  c = 8'h6E;
      4'd3:  c = 8'h74;
      4'd4:  c = 8'h65;
      4'd5:  c = 8'h6E;
      4'd6:  c = 8'h74;
      4'd7:  c = 8'h2D;
      4'd8:  c = 8'h4C;
      4'd9:  c = 8'h65;
      4'd10: c = 8'h6E;
      4'd11: c = 8'h67;
      4'd12: c = 8'h74;
      4'd13: c = 8'h68;
      4'd14: c = 8'h3A;
      4'd15: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hrp_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP response header parser channels
// Valid/ready channels for received bytes and for parse results.
// ----------------------------------------------------------------------------
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] data_byte;

  modport source (output valid, output start_req, output data_byte, input ready);
  modport sink   (input valid, input start_req, input data_byte, output ready);
endinterface

interface hrp_out_if;
  import hrp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CODE_W-1:0]    response_code;
  logic [LEN_OUT_W-1:0] content_length;
  logic                 length_overflow;

  modport source (output valid, output status, output response_code,
                  output content_length, output length_overflow, input ready);
  modport sink   (input valid, input status, input response_code,
                  input content_length, input length_overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/http_response_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The last byte of a parse passes the queue, then its result is registered for output.
// Throughput: one byte per cycle while no held result waits to be taken.
// A two-entry queue lets bytes keep arriving while a result waits at the output.
// Reset (synchronous, active high) empties the queue, drops the output and idles the parser.
// ----------------------------------------------------------------------------
// HTTP response header parser
// Checks the status line, reads the code and the Content-Length of a response.
// ----------------------------------------------------------------------------
module http_response_header_parser (
  input  logic      clk,
  input  logic      rst,
  hrp_in_if.sink    rx,
  hrp_out_if.source result
);
  import hrp_pkg::*;

  logic       push_valid;
  logic       push_ready;
  byte_info_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  byte_info_t pop_item;

  hrp_front u_front (
    .rx         (rx),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  hrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  hrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== rtl/hrp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP response header parser front end
// Accepts received bytes and classifies them for the parser.
// ----------------------------------------------------------------------------
module hrp_front (
  hrp_in_if.sink              rx,
  output logic                push_valid,
  output hrp_pkg::byte_info_t push_item,
  input  logic                push_ready
);
  import hrp_pkg::*;

  assign rx.ready   = push_ready;
  assign push_valid = rx.valid;

  always_comb begin
    push_item.start    = rx.start_req;
    push_item.data     = rx.data_byte;
    push_item.is_digit = (rx.data_byte >= CH_ZERO) && (rx.data_byte <= CH_NINE);
    push_item.digit    = rx.data_byte[3:0];
    push_item.is_cr    = (rx.data_byte == CH_CR);
    push_item.is_lf    = (rx.data_byte == CH_LF);
  end

endmodule
`default_nettype wire

// ===== rtl/hrp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP response header parser byte queue
// Two-entry queue that decouples the front end from the parser.
// ----------------------------------------------------------------------------
module hrp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  hrp_pkg::byte_info_t push_item,
  output logic                push_ready,
  output logic                pop_valid,
  output hrp_pkg::byte_info_t pop_item,
  input  logic                pop_ready
);
  import hrp_pkg::*;

  byte_info_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with single entry");
`endif

endmodule
`default_nettype wire

// ===== rtl/hrp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP response header parser back end
// Runs the parse state machine one byte a cycle while no held result waits to be taken, and holds the result.
// ----------------------------------------------------------------------------
module hrp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  hrp_pkg::byte_info_t pop_item,
  output logic                pop_ready,
  hrp_out_if.source           result
);
  import hrp_pkg::*;

  localparam int PW = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Parse state
  phase_t                 phase;
  logic [3:0]             prefix_pos;
  logic [CODE_W-1:0]      code_acc;
  logic [1:0]             end_trk;
  logic [4:0]             match_pos;
  lsearch_t               lsearch;
  logic [LENGTH_BITS-1:0] len_acc;
  logic                   ovf;

  phase_t                 phase_next;
  logic [3:0]             prefix_pos_next;
  logic [CODE_W-1:0]      code_acc_next;
  logic [1:0]             end_trk_next;
  logic [4:0]             match_pos_next;
  lsearch_t               lsearch_next;
  logic [LENGTH_BITS-1:0] len_acc_next;
  logic                   ovf_next;

  // State as seen by the current byte: a start clears the parse first.
  phase_t                 e_phase;
  logic [3:0]             e_prefix_pos;
  logic [CODE_W-1:0]      e_code;
  logic [1:0]             e_end;
  logic [4:0]             e_match;
  lsearch_t               e_lsearch;
  logic [LENGTH_BITS-1:0] e_len;
  logic                   e_ovf;

  logic                   prefix_ok;
  logic [19:0]            code_prod;
  logic [CODE_W-1:0]      code_sat;
  logic [1:0]             end_upd;
  logic                   end_done;
  logic [4:0]             match_upd;
  lsearch_t               lsearch_upd;
  logic [PW-1:0]          len_prod;
  logic [LENGTH_BITS-1:0] len_upd;
  logic                   ovf_upd;

  logic                   out_valid;
  result_t                out_reg;
  logic                   fire;
  result_t                res_next;
  logic                   take;
  byte_info_t             b;

  assign b         = pop_item;
  assign pop_ready = !out_valid || result.ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    if (b.start) begin
      e_phase      = PH_PREFIX;
      e_prefix_pos = 4'd0;
      e_code       = '0;
      e_end        = 2'd0;
      e_match      = 5'd0;
      e_lsearch    = LS_SEARCH;
      e_len        = '0;
      e_ovf        = 1'b0;
    end else begin
      e_phase      = phase;
      e_prefix_pos = prefix_pos;
      e_code       = code_acc;
      e_end        = end_trk;
      e_match      = match_pos;
      e_lsearch    = lsearch;
      e_len        = len_acc;
      e_ovf        = ovf;
    end
  end

  // Per-byte datapath shared by the next-state and output logic.
  always_comb begin
    prefix_ok = (e_prefix_pos < PREFIX_LEN) && (b.data == proto_char(e_prefix_pos));

    code_prod = (20'(e_code) << 3) + (20'(e_code) << 1) + 20'(b.digit);
    code_sat  = (code_prod[19:16] != 4'd0) ? CODE_MAX : code_prod[CODE_W-1:0];

    // The header ends on the first CR LF CR LF.
    end_done = 1'b0;
    if (b.is_cr) begin
      end_upd = (e_end == 2'd2) ? 2'd3 : 2'd1;
    end else if (b.is_lf) begin
      end_upd  = (e_end == 2'd1) ? 2'd2 : 2'd0;
      end_done = (e_end == 2'd3);
    end else begin
      end_upd = 2'd0;
    end

    match_upd   = e_match;
    lsearch_upd = e_lsearch;
    len_prod    = (PW'(e_len) << 3) + (PW'(e_len) << 1) + PW'(b.digit);
    len_upd     = e_len;
    ovf_upd     = e_ovf;
    unique case (e_lsearch)
      LS_SEARCH: begin
        // The key has no proper border, so a mismatch restarts only on its first byte.
        if ((e_match < KEY_LEN) && (b.data == key_char(e_match[3:0]))) begin
          match_upd = e_match + 5'd1;
        end else begin
          match_upd = (b.data == key_char(4'd0)) ? 5'd1 : 5'd0;
        end
        if (match_upd >= KEY_LEN) lsearch_upd = LS_DIGITS;
      end
      LS_DIGITS: begin
        if (b.is_digit) begin
          if (len_prod[PW-1:LENGTH_BITS] != 4'd0) begin
            len_upd = LEN_MAX;
            ovf_upd = 1'b1;
          end else begin
            len_upd = len_prod[LENGTH_BITS-1:0];
          end
        end else begin
          lsearch_upd = LS_DONE;
        end
      end
      LS_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_next      = e_phase;
    prefix_pos_next = e_prefix_pos;
    code_acc_next   = e_code;
    end_trk_next    = e_end;
    match_pos_next  = e_match;
    lsearch_next    = e_lsearch;
    len_acc_next    = e_len;
    ovf_next        = e_ovf;
    unique case (e_phase)
      PH_PREFIX: begin
        if (!prefix_ok) begin
          phase_next = PH_IDLE;
        end else begin
          prefix_pos_next = e_prefix_pos + 4'd1;
          if (e_prefix_pos + 4'd1 == PREFIX_LEN) phase_next = PH_CODE;
        end
      end
      PH_CODE: begin
        if (b.is_digit) begin
          code_acc_next = code_sat;
        end else if (e_code == CODE_CONTINUE) begin
          phase_next = PH_HDR_CONT;
        end else if (e_code == CODE_OK) begin
          phase_next = PH_HDR_OK;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_HDR_CONT: begin
        end_trk_next = end_upd;
        if (end_done) phase_next = PH_IDLE;
      end
      PH_HDR_OK: begin
        end_trk_next   = end_upd;
        match_pos_next = match_upd;
        lsearch_next   = lsearch_upd;
        len_acc_next   = len_upd;
        ovf_next       = ovf_upd;
        if (end_done) phase_next = PH_IDLE;
      end
      PH_IDLE: begin
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Result generation
  always_comb begin
    fire                     = 1'b0;
    res_next.status          = ST_BAD_PROTOCOL;
    res_next.response_code   = e_code;
    res_next.content_length  = '0;
    res_next.length_overflow = 1'b0;
    unique case (e_phase)
      PH_PREFIX: begin
        fire                   = !prefix_ok;
        res_next.response_code = '0;
      end
      PH_CODE: begin
        if (!b.is_digit && e_code != CODE_CONTINUE && e_code != CODE_OK) begin
          fire            = 1'b1;
          res_next.status = (e_code == CODE_NOT_FOUND) ? ST_NOT_FOUND : ST_UNHANDLED;
        end
      end
      PH_HDR_CONT: begin
        fire            = end_done;
        res_next.status = ST_CONTINUE;
      end
      PH_HDR_OK: begin
        fire = end_done;
        if (lsearch_upd == LS_SEARCH) begin
          res_next.status = ST_LEN_MISSING;
        end else begin
          res_next.status          = ST_OK;
          res_next.content_length  = LEN_OUT_W'(len_upd);
          res_next.length_overflow = ovf_upd;
        end
      end
      PH_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      prefix_pos <= 4'd0;
      code_acc   <= '0;
      end_trk    <= 2'd0;
      match_pos  <= 5'd0;
      lsearch    <= LS_SEARCH;
      len_acc    <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        phase      <= phase_next;
        prefix_pos <= prefix_pos_next;
        code_acc   <= code_acc_next;
        end_trk    <= end_trk_next;
        match_pos  <= match_pos_next;
        lsearch    <= lsearch_next;
        len_acc    <= len_acc_next;
        ovf        <= ovf_next;
      end
      if (take && fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire) out_reg <= res_next;
  end

  assign result.valid           = out_valid;
  assign result.status          = out_reg.status;
  assign result.response_code   = out_reg.response_code;
  assign result.content_length  = out_reg.content_length;
  assign result.length_overflow = out_reg.length_overflow;

`ifndef SYNTH
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_reg.status == ST_OK || out_reg.status == ST_LEN_MISSING))
      |-> (out_reg.response_code == CODE_OK))
    else $error("ok or length-missing result without code 200");
  a_cont_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.status == ST_CONTINUE) |-> (out_reg.response_code == CODE_CONTINUE))
    else $error("continue result without code 100");
  a_len_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_reg.content_length != '0 || out_reg.length_overflow))
      |-> (out_reg.status == ST_OK))
    else $error("length reported on a result other than ok");
  a_idle_after_fire: assert property (@(posedge clk) disable iff (rst)
    (take && fire) |=> (phase == PH_IDLE))
    else $error("parser did not return to idle after a result");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_http_response_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the HTTP response header parser
// Sends response byte streams over the request channel with random gaps and
// back-pressure, runs a parse of its own for every accepted byte, and checks
// every parse result field by field in order.
// ----------------------------------------------------------------------------
module tb_http_response_header_parser;
  import hrp_pkg::*;

  localparam logic [8*9-1:0]  STATUS_SIG = "HTTP/1.1 ";
  localparam logic [8*16-1:0] LENGTH_KEY = "Content-Length: ";

  class parse_scoreboard;
    phase_t                 ph;
    logic [3:0]             sig_pos;
    logic [CODE_W-1:0]      code_acc;
    logic [1:0]             crlf_seen;
    logic [4:0]             key_pos;
    lsearch_t               len_phase;
    logic [LENGTH_BITS-1:0] len_acc;
    logic                   len_sat;
    result_t                due_results[$];
    int                     errors;
    int                     consumed;
    int                     ignored;
    int                     checked;
    int                     overflows;
    int                     status_seen[6];

    function new();
      ph = PH_IDLE;
      restart();
      errors = 0;
      consumed = 0;
      ignored = 0;
      checked = 0;
      overflows = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void restart();
      sig_pos = '0;
      code_acc = '0;
      crlf_seen = '0;
      key_pos = '0;
      len_phase = LS_SEARCH;
      len_acc = '0;
      len_sat = 1'b0;
    endfunction

    // Advances the blank-line tracker; true when CR LF CR LF has just completed.
    function bit header_closed(logic [7:0] c);
      bit hit;
      hit = 1'b0;
      if (c == CH_CR) begin
        crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
      end else if (c == CH_LF) begin
        if (crlf_seen == 2'd1) begin
          crlf_seen = 2'd2;
        end else begin
          hit = (crlf_seen == 2'd3);
          crlf_seen = 2'd0;
        end
      end else begin
        crlf_seen = 2'd0;
      end
      return hit;
    endfunction

    // Runs one accepted byte through the parse and queues the result it ends with.
    function void note_byte(bit start, logic [7:0] c);
      result_t                r;
      bit                     done;
      bit                     is_dig;
      logic [3:0]             d;
      logic [19:0]            v;
      logic [LENGTH_BITS-1:0] lim;
      r = '0;
      done = 1'b0;
      is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
      d = 4'(c - CH_ZERO);
      lim = '1;
      if (!start && ph == PH_IDLE) begin
        ignored++;
        return;
      end
      consumed++;
      if (start) begin
        restart();
        ph = PH_PREFIX;
      end
      case (ph)
        PH_PREFIX: begin
          if (sig_pos >= PREFIX_LEN || c != STATUS_SIG[8*(8-int'(sig_pos)) +: 8]) begin
            r.status = ST_BAD_PROTOCOL;
            done = 1'b1;
          end else begin
            sig_pos++;
            if (sig_pos == PREFIX_LEN) ph = PH_CODE;
          end
        end
        PH_CODE: begin
          if (is_dig) begin
            v = 20'(code_acc) * 20'd10 + 20'(d);
            code_acc = (v > 20'(CODE_MAX)) ? CODE_MAX : v[CODE_W-1:0];
          end else if (code_acc == CODE_CONTINUE) begin
            ph = PH_HDR_CONT;
          end else if (code_acc == CODE_OK) begin
            ph = PH_HDR_OK;
          end else begin
            r.status = (code_acc == CODE_NOT_FOUND) ? ST_NOT_FOUND : ST_UNHANDLED;
            r.response_code = code_acc;
            done = 1'b1;
          end
        end
        PH_HDR_CONT: begin
          if (header_closed(c)) begin
            r.status = ST_CONTINUE;
            r.response_code = code_acc;
            done = 1'b1;
          end
        end
        PH_HDR_OK: begin
          if (len_phase == LS_SEARCH) begin
            // The key has no repeated prefix, so a miss restarts only on its first letter.
            if (key_pos < KEY_LEN && c == LENGTH_KEY[8*(15-int'(key_pos)) +: 8]) begin
              key_pos++;
            end else begin
              key_pos = (c == LENGTH_KEY[127:120]) ? 5'd1 : 5'd0;
            end
            if (key_pos >= KEY_LEN) len_phase = LS_DIGITS;
          end else if (len_phase == LS_DIGITS) begin
            if (!is_dig) begin
              len_phase = LS_DONE;
            end else if (len_acc > (lim - LENGTH_BITS'(d)) / 10) begin
              len_acc = lim;
              len_sat = 1'b1;
            end else begin
              len_acc = len_acc * 10 + LENGTH_BITS'(d);
            end
          end
          if (header_closed(c)) begin
            r.response_code = code_acc;
            done = 1'b1;
            if (len_phase == LS_SEARCH) begin
              r.status = ST_LEN_MISSING;
            end else begin
              r.status = ST_OK;
              r.content_length = LEN_OUT_W'(len_acc);
              r.length_overflow = len_sat;
            end
          end
        end
        default: ph = PH_IDLE;
      endcase
      if (done) begin
        ph = PH_IDLE;
        due_results.push_back(r);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result with no parse outstanding: status %0d, code %0d",
               got.status, got.response_code);
        errors++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      status_seen[want.status]++;
      overflows += want.length_overflow;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.response_code !== want.response_code) begin
        $error("response_code: expected %0d, got %0d", want.response_code, got.response_code);
        errors++;
      end
      if (got.content_length !== want.content_length) begin
        $error("content_length: expected %0d, got %0d", want.content_length,
               got.content_length);
        errors++;
      end
      if (got.length_overflow !== want.length_overflow) begin
        $error("length_overflow: expected %0d, got %0d", want.length_overflow,
               got.length_overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  hrp_in_if  rx_if ();
  hrp_out_if res_if ();

  http_response_header_parser uut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if)
  );

  parse_scoreboard sb;
  logic [7:0]      msg[$];
  bit              src_lively;
  bit              snk_lively;
  bit              hold_req;
  int              hold_left;
  int              stall_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb_http_response_header_parser NOT OK");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none at all when not lively.
  function automatic int pick_gap(input bit lively);
    int r;
    if (!lively) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endfunction

  function automatic void put_num(input int unsigned n);
    put($sformatf("%0d", n));
  endfunction

  function automatic void crlf();
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
  endfunction

  task automatic send_byte(input bit s, input logic [7:0] b);
    int gap;
    gap = pick_gap(src_lively);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.start_req <= s;
    rx_if.data_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    sb.note_byte(s, b);
  endtask

  // A loose message carries no start flag on any byte.
  task automatic send_msg(input bit loose);
    for (int i = 0; i < msg.size(); i++) send_byte(!loose && i == 0, msg[i]);
    msg.delete();
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void gen_response(output bit loose);
    int          kind;
    int          pick;
    int          nh;
    int          len_slot;
    int          cut;
    logic [7:0]  b;
    loose = 1'b0;
    kind = $urandom_range(99);
    if (kind < 8) begin
      put("HTTP/1.1 200 OK");
      pick = $urandom_range(8);
      msg[pick] = msg[pick] ^ (8'd1 << $urandom_range(7));
    end else if (kind < 14) begin
      loose = ($urandom_range(1) == 0);
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom));
    end else begin
      put("HTTP/1.1 ");
      pick = $urandom_range(99);
      if (pick < 40) put("200");
      else if (pick < 55) put("100");
      else if (pick < 68) put("404");
      else if (pick < 78) put_num($urandom_range(999));
      else if (pick < 84) put_num($urandom);
      else if (pick < 88) ; // no code digits at all
      else if (pick < 91) put("0200");
      else if (pick < 94) put("00100");
      else put_num($urandom_range(65535));
      pick = $urandom_range(9);
      if (pick == 1) begin
        do b = 8'($urandom); while (b >= CH_ZERO && b <= CH_NINE);
        msg.push_back(b);
      end else if (pick != 0) begin
        put(" Reason");
      end
      crlf();
      nh = $urandom_range(4);
      len_slot = ($urandom_range(4) == 0) ? -1 : $urandom_range(nh);
      for (int i = 0; i <= nh; i++) begin
        if (i == len_slot) begin
          // Sometimes a second length line follows; only the first one may count.
          repeat (($urandom_range(4) == 0) ? 2 : 1) begin
            put("Content-Length: ");
            pick = $urandom_range(99);
            if (pick < 45) put_num($urandom_range(99999));
            else if (pick < 65) put_num($urandom);
            else if (pick < 72) put("4294967295");
            else if (pick < 82) begin
              repeat ($urandom_range(11, 24)) msg.push_back(CH_ZERO + 8'($urandom_range(9)));
            end else if (pick < 90) ; // key with no digits
            else put("n/a");
            crlf();
          end
        end
        if (i < nh) begin
          pick = $urandom_range(9);
          case (pick)
            0: put("Server: tb");
            1: put("Content-Type: text/plain");
            2: put("content-length: 12");
            3: put("Content-Length:12");
            4: put("Content-Lengt: 3");
            5: put("Content-Length : 5");
            6: repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom_range(32, 126)));
            7: repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
            8: put("CContent-Length: 77");
            default: begin
              put("X-Tag: ");
              put_num($urandom);
            end
          endcase
          crlf();
        end
      end
      crlf();
      if ($urandom_range(11) == 0) begin
        cut = $urandom_range(1, msg.size() - 1);
        while (msg.size() > cut) void'(msg.pop_back());
      end
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
      end
    end
  endfunction

  // Result side: checks every accepted result and applies back-pressure.
  initial begin
    result_t got;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got.status          = res_if.status;
        got.response_code   = res_if.response_code;
        got.content_length  = res_if.content_length;
        got.length_overflow = res_if.length_overflow;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        stall_left = ($urandom_range(3) == 0) ? pick_gap(snk_lively) : 0;
        res_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    bit loose;
    sb = new();
    rx_if.valid     = 1'b0;
    rx_if.start_req = 1'b0;
    rx_if.data_byte = 8'h00;
    res_if.ready    = 1'b0;
    src_lively = 1'b1;
    snk_lively = 1'b1;
    hold_req   = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed responses.
    put("HTTP/1.1 200 OK"); crlf(); put("Content-Length: 4294967295"); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1 200 OK"); crlf(); put("Content-Length: 4294967296"); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1 200 OK"); crlf(); put("Content-Length: 99999999999999999999999"); crlf();
    crlf();
    send_msg(0);
    put("HTTP/1.1 200 OK"); crlf(); put("Content-Length: 000000000000000012345"); crlf();
    crlf();
    send_msg(0);
    put("HTTP/1.1 200 OK"); crlf(); put("Server: tb"); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1 100 Continue"); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1 404 Not Found"); crlf();
    send_msg(0);
    put("HTTP/1.1 301 Moved");
    send_msg(0);
    put("HTTP/1.1 OK");
    send_msg(0);
    put("HTTP/1.1 9999999 x");
    send_msg(0);
    put("HTTP/1.1 65535 ");
    send_msg(0);
    put("HTTP/1.1 0200 OK"); crlf(); put("Content-Length: 0"); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1X");
    send_msg(0);
    put("XTTP/1.1 200");
    send_msg(0);
    put("HTTP/1.0 200");
    send_msg(0);
    // A new start in the middle of a response drops the old one.
    put("HTTP/1");
    send_msg(0);
    put("HTTP/1.1 404 ");
    send_msg(0);
    msg.push_back(8'h00); msg.push_back(8'hFF); put("HTTP/1.1 200 ");
    send_msg(1);
    put("HTTP/1.1 200 OK"); crlf(); put("Content-Length: x"); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1 200 OK"); crlf(); put("Content-Length: 7"); crlf();
    put("Content-Length: 9"); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1 200 OK"); crlf(); put("Content-Length: "); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1 200 OK"); crlf(); put("content-length: 5"); crlf();
    put("CContent-Length: 42"); crlf(); crlf();
    send_msg(0);
    put("HTTP/1.1 200 OK"); crlf(); put("Content-Length: 3");
    msg.push_back(CH_CR); msg.push_back(CH_CR); msg.push_back(CH_LF);
    msg.push_back(CH_CR); msg.push_back(CH_LF);
    send_msg(0);
    put("HTTP/1.1 100 x"); msg.push_back(CH_LF); msg.push_back(8'h00); msg.push_back(8'hFF);
    msg.push_back(CH_LF); crlf(); crlf();
    send_msg(0);
    drain();

    // Hold the result side off while single-byte responses keep coming.
    src_lively = 1'b0;
    hold_req = 1'b1;
    repeat (24) begin
      msg.push_back(8'h58);
      send_msg(0);
    end
    put("HTTP/1.1 404 ");
    send_msg(0);
    drain();

    while (sb.consumed + sb.ignored < 1900) begin
      if ($urandom_range(15) == 0) snk_lively = ($urandom_range(3) != 0);
      src_lively = ($urandom_range(4) != 0);
      gen_response(loose);
      send_msg(loose);
      if ($urandom_range(40) == 0) drain();
    end
    drain();

    $display("Covered %0d parsed bytes, %0d ignored bytes and %0d checked results.",
             sb.consumed, sb.ignored, sb.checked);
    $display("Statuses bad/cont/ok/404/other/nolen: %0d %0d %0d %0d %0d %0d, overflows %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.status_seen[5], sb.overflows);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("tb_http_response_header_parser OK");
    end else begin
      $display("tb_http_response_header_parser NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hrp_pkg.sv
rtl/hrp_ifs.sv
rtl/hrp_front.sv
rtl/hrp_queue.sv
rtl/hrp_back.sv
rtl/http_response_header_parser.sv
dv/tb_http_response_header_parser.sv
